// ===== hdl/fbm_value_noise_2d_macros.svh =====
// Assertion macros shared by the checker.
`ifndef FBM_VALUE_NOISE_2D_MACROS_SVH
`define FBM_VALUE_NOISE_2D_MACROS_SVH
// Implication under reset.
`define FBM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication under reset.
`define FBM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/fbm_pkg.sv =====
// Shared constants and an arithmetic helper for the noise pipeline.
package fbm_pkg;
    localparam int OCTAVES   = 4;
    localparam int FRAC_BITS = 16;
    localparam int CW        = 24;
    localparam int SEED_W    = 32;
    localparam int HW        = FRAC_BITS;
    localparam int SUM_W     = FRAC_BITS + 1;
    localparam logic [31:0] HASH_K1 = 32'd15731;
    localparam logic [31:0] HASH_K2 = 32'd789221;
    localparam logic [31:0] HASH_K3 = 32'd1376312589;
    localparam logic [31:0] SEED_RST = 32'd1;

    typedef logic [HW-1:0] frac_t;

    // Final hash stage after the cubic: mask and cut to fraction bits.
    function automatic frac_t hash_cut(input logic [31:0] v);
        logic [31:0] m;
        begin
            m = v & 32'h7fffffff;
            hash_cut = frac_t'(m >> (31 - FRAC_BITS));
        end
    endfunction
endpackage

// ===== hdl/fbm_value_noise_2d.sv =====
// Fractal value noise over a 2D fixed-point point, one item per cycle unless the output stalls.
// Input accept to output valid passes 7 register stages: 6 octave stages and the sum register.
// Throughput: one item per cycle while the output is not stalled; each octave is a parallel 6-stage pipe.
// A stall freezes the whole pipe; the output register frees only when taken.
// Reset clears valid bits and loads seed 1; data registers are not reset.
module fbm_value_noise_2d
    import fbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CW-1:0]     coord_x,
    input  logic [CW-1:0]     coord_y,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       noise_value,
    input  logic              cfg_we,
    input  logic [SEED_W-1:0] cfg_wdata
);
    localparam int DEPTH = 7;
    logic [SEED_W-1:0] seed_reg;
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic en;
    frac_t oct_val [OCTAVES];
    logic [SUM_W-1:0] sum;
    logic [15:0] res_reg;

    assign en = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[DEPTH-2:0], in_valid};

    for (genvar i = 0; i < OCTAVES; i++)
    begin : g_oct
        fbm_octave u_oct (
            .clk  (clk),
            .en   (en),
            .seed (seed_reg),
            .px   (32'(coord_x) << i),
            .py   (32'(coord_y) << i),
            .value(oct_val[i])
        );
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < OCTAVES; i++)
            sum = sum + SUM_W'(oct_val[i] >> (i + 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RST;
            vld_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                seed_reg <= cfg_wdata;
            if (en)
                vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= (FRAC_BITS > 16) ? 16'(sum >> (FRAC_BITS - 16))
                                        : 16'(sum << (16 - FRAC_BITS));
    end

    assign out_valid   = vld_reg[DEPTH-1];
    assign noise_value = res_reg;
endmodule

// ===== hdl/fbm_octave.sv =====
// One octave: lattice hashing, smoothstep weights and bilinear blend, pipelined.
module fbm_octave
    import fbm_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SEED_W-1:0] seed,
    input  logic [31:0]       px,
    input  logic [31:0]       py,
    output frac_t             value
);
    // stage 1: index*seed, weight t^2
    logic [31:0] n_reg [4];
    logic [HW-1:0] tx_reg, ty_reg;
    logic [2*HW-1:0] tx2_reg, ty2_reg;
    // stage 2: xorshift, n*n, weight finish
    logic [31:0] x_reg [4];
    logic [HW:0] sx_reg, sy_reg;
    logic [31:0] nn_reg [4];
    // stage 3: polynomial
    logic [31:0] p_reg [4];
    logic [31:0] x3_reg [4];
    logic [HW:0] sx3_reg, sy3_reg;
    // stage 4: n*p + k3
    frac_t h_reg [4];
    logic [HW:0] sx4_reg, sy4_reg;
    // stage 5: x blends
    frac_t lo_reg, hi_reg;
    logic [HW:0] sy5_reg;
    frac_t val_reg;

    logic [31:0] xi, yi, row0, row1;
    logic [31:0] idx [4];
    logic [31:0] n_next [4];
    logic [HW+1:0] wx, wy;
    logic [2*HW+1:0] sxp, syp;

    function automatic frac_t blend(input frac_t a, input frac_t b, input logic [HW:0] s);
        logic [HW:0] d;
        logic [2*HW+1:0] pr;
        begin
            d = (b >= a) ? {1'b0, b - a} : {1'b0, a - b};
            pr = d * s;
            blend = (b >= a) ? frac_t'(a + pr[2*HW-1:HW]) : frac_t'(a - pr[2*HW-1:HW]);
        end
    endfunction

    always_comb
    begin
        xi = px >> FRAC_BITS;
        yi = py >> FRAC_BITS;
        row0 = (yi << 8) + xi;
        row1 = ((yi + 32'd1) << 8) + xi;
        idx[0] = row0;
        idx[1] = row0 + 32'd1;
        idx[2] = row1;
        idx[3] = row1 + 32'd1;
        for (int k = 0; k < 4; k++)
            n_next[k] = idx[k] * seed;
    end

    // 3*ONE - 2*t, fits HW+2 bits
    assign wx = (HW+2)'(3 << HW) - {tx_reg, 1'b0};
    assign wy = (HW+2)'(3 << HW) - {ty_reg, 1'b0};

    // full-width product before the weight shift
    assign sxp = tx2_reg[2*HW-1:HW] * wx;
    assign syp = ty2_reg[2*HW-1:HW] * wy;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                n_reg[k]  <= n_next[k];
                x_reg[k]  <= (n_reg[k] << 13) ^ n_reg[k];
                nn_reg[k] <= ((n_reg[k] << 13) ^ n_reg[k]) * ((n_reg[k] << 13) ^ n_reg[k]);
                p_reg[k]  <= nn_reg[k] * HASH_K1 + HASH_K2;
                x3_reg[k] <= x_reg[k];
                h_reg[k]  <= hash_cut(x3_reg[k] * p_reg[k] + HASH_K3);
            end
            tx_reg  <= px[HW-1:0];
            ty_reg  <= py[HW-1:0];
            tx2_reg <= px[HW-1:0] * px[HW-1:0];
            ty2_reg <= py[HW-1:0] * py[HW-1:0];
            sx_reg  <= sxp[2*HW:HW];
            sy_reg  <= syp[2*HW:HW];
            sx3_reg <= sx_reg;
            sy3_reg <= sy_reg;
            sx4_reg <= sx3_reg;
            sy4_reg <= sy3_reg;
            lo_reg  <= blend(h_reg[0], h_reg[1], sx4_reg);
            hi_reg  <= blend(h_reg[2], h_reg[3], sx4_reg);
            sy5_reg <= sy4_reg;
            val_reg <= blend(lo_reg, hi_reg, sy5_reg);
        end
    end

    assign value = val_reg;
endmodule

// ===== hdl/fbm_checker.sv =====
// Port-level checker for the noise block, bound to the top level.
`include "fbm_value_noise_2d_macros.svh"
module fbm_checker
    import fbm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] noise_value
);
    `FBM_ASSERT_IMP(a_ready_free, !out_valid, in_ready)
    `FBM_ASSERT_IMP(a_ready_stall, out_valid && !out_ready, !in_ready)
    `FBM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(noise_value))
endmodule

bind fbm_value_noise_2d fbm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
);
